[rtl/tll_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tll_pkg;

  localparam int DEF_PAGES = 1024;

  // Page sites
  localparam logic [1:0] SITE_NONE     = 2'd0;
  localparam logic [1:0] SITE_INACTIVE = 2'd1;
  localparam logic [1:0] SITE_ACTIVE   = 2'd2;
  localparam logic [1:0] SITE_RADIX    = 2'd3;

  // Command codes
  localparam logic [3:0] CMD_ALLOC     = 4'd0;
  localparam logic [3:0] CMD_ADD       = 4'd1;
  localparam logic [3:0] CMD_SETBACK   = 4'd2;
  localparam logic [3:0] CMD_DELETE    = 4'd3;
  localparam logic [3:0] CMD_RD_MISS   = 4'd4;
  localparam logic [3:0] CMD_RD_HIT    = 4'd5;
  localparam logic [3:0] CMD_WR_MISS   = 4'd6;
  localparam logic [3:0] CMD_WR_HIT    = 4'd7;
  localparam logic [3:0] CMD_WB_RETURN = 4'd8;
  localparam logic [3:0] CMD_REBALANCE = 4'd9;
  localparam logic [3:0] CMD_SHRINK    = 4'd10;

  // List insertion kinds
  localparam logic [1:0] PUSH_NONE  = 2'd0;
  localparam logic [1:0] PUSH_IHEAD = 2'd1;
  localparam logic [1:0] PUSH_AHEAD = 2'd2;
  localparam logic [1:0] PUSH_ITAIL = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_TOTAL_PAGES  = 2'd0;
  localparam logic [1:0] REG_TOTAL_SHIFT  = 2'd1;
  localparam logic [1:0] REG_LIST_SHIFT   = 2'd2;
  localparam logic [1:0] REG_MIN_INACTIVE = 2'd3;

  localparam logic [10:0] RST_TOTAL_PAGES  = 11'd1024;
  localparam logic [3:0]  RST_TOTAL_SHIFT  = 4'd1;
  localparam logic [3:0]  RST_LIST_SHIFT   = 4'd1;
  localparam logic [10:0] RST_MIN_INACTIVE = 11'd32;

  typedef struct packed {
    logic [1:0] site;
    logic       refd;
    logic       actv;
  } meta_t;

  typedef struct packed {
    logic       unlink;
    logic [1:0] push;
    logic       meta_we;
    meta_t      meta;
    logic       demote;
  } plan_t;

endpackage

`default_nettype wire

[rtl/two_list_lru_page_replacement.sv]
`timescale 1ns / 1ps
`default_nettype none
// List commands read the page, unlink it, push it onto a list as planned, write its marks
// and raise the result; ignored commands and alloc on an empty inactive list go straight to
// the result. Rebalance demotes pages from the active tail; shrink sweeps every page, then
// walks the active list from its tail, clearing marks or demoting. One transaction is in work
// at a time; a result waits while a previous one is stalled, and the next is accepted once it
// is in the output register. rst is synchronous; a clearing pass then zeroes the page marks,
// and no transaction is accepted until it ends. Configuration writes are taken throughout.
module two_list_lru_page_replacement import tll_pkg::*; #(
  parameter int PAGES = DEF_PAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  cmd,
  input  logic [9:0]  page,
  input  logic        in_writeback,
  input  logic        to_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  page_out,
  output logic        found,
  output logic [10:0] inactive_count,
  output logic [10:0] active_count,
  output logic [10:0] moved
);

  // Pointers carry one extra bit so that the value PAGES marks the end of a list.
  localparam int PW = $clog2(PAGES);
  localparam int LW = PW + 1;
  localparam int SW = LW + 16;
  localparam logic [LW-1:0] NIL  = LW'(PAGES);
  localparam logic [LW-1:0] LAST = LW'(PAGES - 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_BAL    = 4'd2;
  localparam logic [3:0] ST_FETCH  = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_PUSH1  = 4'd5;
  localparam logic [3:0] ST_PUSH2  = 4'd6;
  localparam logic [3:0] ST_META   = 4'd7;
  localparam logic [3:0] ST_SWEEP  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state;

  // Configuration
  logic [10:0] pool_limit;
  logic [3:0]  total_shift;
  logic [3:0]  list_shift;
  logic [10:0] min_inactive;

  // List anchors and lengths
  logic [LW-1:0] ihead, itail, ahead, atail;
  logic [LW-1:0] ilen, alen;

  // Transaction in work
  logic [3:0]    cmd_r;
  logic          wb_r;
  logic          ta_r;
  logic [LW-1:0] cur;
  logic [LW-1:0] pv_r;
  plan_t         plan_r;
  plan_t         plan_c;
  logic [LW-1:0] rem;
  logic [LW-1:0] idx;
  logic          last_v;
  logic [PW-1:0] last_addr;
  logic [LW-1:0] moved_r;
  logic          found_r;
  logic [9:0]    pout_r;

  // Page stores: links and marks
  logic [LW-1:0] nxt_mem  [PAGES];
  logic [LW-1:0] prv_mem  [PAGES];
  meta_t         meta_mem [PAGES];
  logic [LW-1:0] nxt_q, prv_q;
  meta_t         meta_q;
  logic [PW-1:0] rd_addr;

  logic          nxt_we, prv_we, meta_we;
  logic [PW-1:0] nxt_wa, prv_wa, meta_wa;
  logic [LW-1:0] nxt_wd, prv_wd;
  meta_t         meta_wd;

  logic [LW-1:0] push_hd;
  logic [SW-1:0] ina_sh, act_sh;
  logic          bal_go;
  logic [LW-1:0] bal_count;
  logic          page_ok;

  assign in_stall = (state != ST_IDLE);
  assign page_ok  = 32'(page) < 32'(PAGES);
  assign push_hd  = (plan_r.push == PUSH_AHEAD) ? ahead : ihead;

  tll_plan u_plan (
    .cmd    (cmd_r),
    .wb     (wb_r),
    .to_act (ta_r),
    .cur    (meta_q),
    .plan   (plan_c)
  );

  // Rebalance count: none if active is empty or shifted inactive exceeds pool_limit; else all
  // of active when inactive is below its floor, half when active outweighs it, else nothing.
  always_comb begin
    ina_sh    = SW'(ilen) << total_shift;
    act_sh    = SW'(alen) << list_shift;
    bal_go    = 1'b0;
    bal_count = '0;
    if ((alen != '0) && !(ina_sh > SW'(pool_limit))) begin
      if (SW'(ilen) < SW'(min_inactive)) begin
        bal_go    = 1'b1;
        bal_count = alen;
      end else if (act_sh > SW'(ilen)) begin
        bal_go    = 1'b1;
        bal_count = alen >> 1;
      end
    end
  end

  // Read address: the sweep walks every page, everything else works on cur.
  always_comb begin
    if (state == ST_SWEEP) begin
      rd_addr = (idx < NIL) ? idx[PW-1:0] : '0;
    end else begin
      rd_addr = cur[PW-1:0];
    end
  end

  // Store write ports, one per store and cycle
  always_comb begin
    nxt_we  = 1'b0;
    nxt_wa  = cur[PW-1:0];
    nxt_wd  = NIL;
    prv_we  = 1'b0;
    prv_wa  = cur[PW-1:0];
    prv_wd  = NIL;
    meta_we = 1'b0;
    meta_wa = cur[PW-1:0];
    meta_wd = plan_r.meta;
    case (state)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = idx[PW-1:0];
        meta_wd = '0;
      end
      ST_SWEEP: begin
        // drop the referenced mark of every inactive page
        if (last_v && (meta_q.site == SITE_INACTIVE)) begin
          meta_we      = 1'b1;
          meta_wa      = last_addr;
          meta_wd      = meta_q;
          meta_wd.refd = 1'b0;
        end
      end
      ST_DECIDE: begin
        // bridge the neighbors over the page
        if (plan_c.unlink) begin
          if (prv_q != NIL) begin
            nxt_we = 1'b1;
            nxt_wa = prv_q[PW-1:0];
            nxt_wd = nxt_q;
          end
          if (nxt_q != NIL) begin
            prv_we = 1'b1;
            prv_wa = nxt_q[PW-1:0];
            prv_wd = prv_q;
          end
        end
      end
      ST_PUSH1: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (plan_r.push == PUSH_ITAIL) begin
          nxt_wd = NIL;
          prv_wd = itail;
        end else begin
          nxt_wd = push_hd;
          prv_wd = NIL;
        end
      end
      ST_PUSH2: begin
        if (plan_r.push == PUSH_ITAIL) begin
          if (itail != NIL) begin
            nxt_we = 1'b1;
            nxt_wa = itail[PW-1:0];
            nxt_wd = cur;
          end
        end else if (push_hd != NIL) begin
          prv_we = 1'b1;
          prv_wa = push_hd[PW-1:0];
          prv_wd = cur;
        end
      end
      ST_META: begin
        meta_we = plan_r.meta_we;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    nxt_q  <= nxt_mem[rd_addr];
    prv_q  <= prv_mem[rd_addr];
    meta_q <= meta_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      idx          <= '0;
      last_v       <= 1'b0;
      pool_limit   <= RST_TOTAL_PAGES;
      total_shift  <= RST_TOTAL_SHIFT;
      list_shift   <= RST_LIST_SHIFT;
      min_inactive <= RST_MIN_INACTIVE;
      ihead        <= NIL;
      itail        <= NIL;
      ahead        <= NIL;
      atail        <= NIL;
      ilen         <= '0;
      alen         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TOTAL_PAGES:  pool_limit   <= cfg_data;
          REG_TOTAL_SHIFT:  total_shift  <= cfg_data[3:0];
          REG_LIST_SHIFT:   list_shift   <= cfg_data[3:0];
          REG_MIN_INACTIVE: min_inactive <= cfg_data;
          default: begin
          end
        endcase
      end

      // drop a taken result unless a new one replaces it this cycle
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      last_v    <= (state == ST_SWEEP) && (idx < NIL);
      last_addr <= rd_addr;

      unique case (state)
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd;
            wb_r    <= in_writeback;
            ta_r    <= to_active;
            moved_r <= '0;
            found_r <= 1'b0;
            pout_r  <= '0;
            case (cmd) inside
              CMD_ALLOC: begin
                cur   <= itail;
                state <= (itail != NIL) ? ST_FETCH : ST_DONE;
              end
              CMD_REBALANCE: begin
                state <= ST_BAL;
              end
              CMD_SHRINK: begin
                idx   <= '0;
                state <= ST_SWEEP;
              end
              [CMD_ADD:CMD_WB_RETURN]: begin
                cur   <= LW'(page);
                state <= page_ok ? ST_FETCH : ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_BAL: begin
          rem <= bal_count;
          cur <= atail;
          if (bal_go && (bal_count != '0)) begin
            state <= ST_FETCH;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_FETCH: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          plan_r <= plan_c;
          pv_r   <= prv_q;
          if (plan_c.unlink) begin
            if (meta_q.site == SITE_ACTIVE) begin
              if (prv_q == NIL) ahead <= nxt_q;
              if (nxt_q == NIL) atail <= prv_q;
              alen <= alen - 1'b1;
            end else begin
              if (prv_q == NIL) ihead <= nxt_q;
              if (nxt_q == NIL) itail <= prv_q;
              ilen <= ilen - 1'b1;
            end
          end
          if (cmd_r == CMD_ALLOC) begin
            found_r <= 1'b1;
            pout_r  <= 10'(cur);
          end
          if (plan_c.demote) begin
            moved_r <= moved_r + 1'b1;
          end
          state <= (plan_c.push != PUSH_NONE) ? ST_PUSH1 : ST_META;
        end
        ST_PUSH1: begin
          state <= ST_PUSH2;
        end
        ST_PUSH2: begin
          // advance the anchors of the receiving list
          if (plan_r.push == PUSH_ITAIL) begin
            if (itail == NIL) ihead <= cur;
            itail <= cur;
            ilen  <= ilen + 1'b1;
          end else if (plan_r.push == PUSH_AHEAD) begin
            if (ahead == NIL) atail <= cur;
            ahead <= cur;
            alen  <= alen + 1'b1;
          end else begin
            if (ihead == NIL) itail <= cur;
            ihead <= cur;
            ilen  <= ilen + 1'b1;
          end
          state <= ST_META;
        end
        ST_META: begin
          if (cmd_r == CMD_REBALANCE) begin
            rem <= rem - 1'b1;
            cur <= atail;
            state <= (rem == LW'(1)) ? ST_DONE : ST_FETCH;
          end else if (cmd_r == CMD_SHRINK) begin
            // walk toward the newest active page
            cur   <= pv_r;
            state <= (pv_r == NIL) ? ST_DONE : ST_FETCH;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          if (idx != NIL) begin
            idx <= idx + 1'b1;
          end else begin
            cur   <= atail;
            state <= (atail == NIL) ? ST_DONE : ST_FETCH;
          end
        end
        ST_DONE: begin
          // hold the result while the previous one is still stalled
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            page_out       <= pout_r;
            found          <= found_r;
            inactive_count <= 11'(ilen);
            active_count   <= 11'(alen);
            moved          <= 11'(moved_r);
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    ((LW+1)'(ilen) + (LW+1)'(alen)) <= (LW+1)'(PAGES))
    else $error("list lengths exceed the page pool");

  a_inactive_empty: assert property (@(posedge clk) disable iff (rst)
    ((ihead == NIL) == (ilen == '0)) && ((itail == NIL) == (ilen == '0)))
    else $error("inactive anchors disagree with its length");

  a_active_empty: assert property (@(posedge clk) disable iff (rst)
    ((ahead == NIL) == (alen == '0)) && ((atail == NIL) == (alen == '0)))
    else $error("active anchors disagree with its length");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule

`default_nettype wire

[rtl/tll_plan.sv]
`timescale 1ns / 1ps
`default_nettype none

// Decide unlink, insertion and new marks of one page from its stored marks.
module tll_plan import tll_pkg::*; (
  input  logic [3:0] cmd,
  input  logic       wb,
  input  logic       to_act,
  input  meta_t      cur,
  output plan_t      plan
);

  logic listed;
  logic move;

  always_comb begin
    listed = (cur.site == SITE_INACTIVE) || (cur.site == SITE_ACTIVE);
    move   = wb ? (!cur.actv && cur.refd) : (cur.site == SITE_INACTIVE);
    plan         = '0;
    plan.push    = PUSH_NONE;
    plan.meta    = cur;
    unique case (cmd)
      CMD_ALLOC: begin
        plan.unlink    = listed;
        plan.meta_we   = 1'b1;
        plan.meta.site = SITE_NONE;
        plan.meta.refd = 1'b0;
        plan.meta.actv = 1'b0;
      end
      CMD_ADD: begin
        plan.unlink    = listed;
        plan.push      = cur.actv ? PUSH_AHEAD : PUSH_IHEAD;
        plan.meta_we   = 1'b1;
        plan.meta.site = cur.actv ? SITE_ACTIVE : SITE_INACTIVE;
      end
      CMD_SETBACK: begin
        plan.unlink    = listed;
        plan.push      = PUSH_ITAIL;
        plan.meta_we   = 1'b1;
        plan.meta.site = SITE_INACTIVE;
      end
      CMD_DELETE: begin
        plan.unlink    = listed;
        plan.meta_we   = listed;
        plan.meta.site = SITE_NONE;
      end
      CMD_RD_MISS: begin
        plan.unlink    = listed;
        plan.push      = PUSH_IHEAD;
        plan.meta_we   = 1'b1;
        plan.meta.site = SITE_INACTIVE;
        plan.meta.refd = 1'b1;
      end
      CMD_RD_HIT: begin
        if (!cur.refd) begin
          plan.meta_we   = 1'b1;
          plan.meta.refd = 1'b1;
        end else if (!cur.actv) begin
          plan.meta_we   = 1'b1;
          plan.meta.refd = 1'b0;
          plan.meta.actv = 1'b1;
          if (move) begin
            plan.unlink    = listed;
            plan.push      = PUSH_AHEAD;
            plan.meta.site = SITE_ACTIVE;
          end
        end
      end
      CMD_WR_MISS: begin
        plan.unlink    = listed;
        plan.meta_we   = 1'b1;
        plan.meta.site = SITE_RADIX;
        plan.meta.refd = 1'b1;
      end
      CMD_WR_HIT: begin
        plan.unlink    = listed;
        plan.meta_we   = 1'b1;
        plan.meta.site = SITE_RADIX;
        if (!cur.refd) begin
          plan.meta.refd = 1'b1;
        end else if (!cur.actv) begin
          plan.meta.refd = 1'b0;
          plan.meta.actv = 1'b1;
        end
      end
      CMD_WB_RETURN: begin
        plan.unlink    = listed;
        plan.push      = to_act ? PUSH_AHEAD : PUSH_IHEAD;
        plan.meta_we   = 1'b1;
        plan.meta.site = to_act ? SITE_ACTIVE : SITE_INACTIVE;
      end
      CMD_REBALANCE: begin
        plan.unlink    = listed;
        plan.push      = PUSH_IHEAD;
        plan.meta_we   = 1'b1;
        plan.meta.site = SITE_INACTIVE;
        plan.meta.refd = 1'b0;
        plan.meta.actv = 1'b0;
        plan.demote    = 1'b1;
      end
      CMD_SHRINK: begin
        plan.meta_we = 1'b1;
        if (cur.refd) begin
          plan.meta.refd = 1'b0;
        end else begin
          plan.unlink    = listed;
          plan.push      = PUSH_IHEAD;
          plan.meta.site = SITE_INACTIVE;
          plan.meta.refd = 1'b0;
          plan.meta.actv = 1'b0;
          plan.demote    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the two-list LRU page replacement block.
// A directed table runs first, then random command streams in several
// configuration phases. Every accepted transaction is run through a local
// model of both lists and the page marks; the predicted result, or the typed result of a
// table row that gives one, is queued and compared field by field with each result
// transaction taken from the block.
module tb_top;
  import tll_pkg::*;

  localparam int NPG = 1024;
  localparam int NIL = NPG;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RAND_PER_PHASE = 210;

  typedef struct packed {
    logic [9:0]  page_out;
    logic        found;
    logic [10:0] inact;
    logic [10:0] act;
    logic [10:0] moved;
  } lru_result_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [9:0]  page;
    logic        wb;
    logic        ta;
  } lru_cmd_t;

  typedef struct packed {
    lru_cmd_t    op;
    logic        typed;
    lru_result_t res;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  cmd = '0;
  logic [9:0]  page = '0;
  logic        in_writeback = 1'b0;
  logic        to_active = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  page_out;
  logic        found;
  logic [10:0] inactive_count;
  logic [10:0] active_count;
  logic [10:0] moved;

  two_list_lru_page_replacement uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the list state and configuration.
  logic [10:0] nxt [NPG];
  logic [10:0] prv [NPG];
  logic [1:0]  site [NPG];
  bit          refm [NPG];
  bit          actm [NPG];
  int          ihd, itl, ahd, atl, ilen, alen;
  int          cfg_total, cfg_tshift, cfg_lshift, cfg_min;

  lru_result_t expected_results[$];
  int          errs = 0;
  bit          no_idle = 0;

  function automatic void lists_clear();
    for (int i = 0; i < NPG; i++) begin
      nxt[i] = NIL; prv[i] = NIL; site[i] = SITE_NONE; refm[i] = 0; actm[i] = 0;
    end
    ihd = NIL; itl = NIL; ahd = NIL; atl = NIL; ilen = 0; alen = 0;
    cfg_total = RST_TOTAL_PAGES; cfg_tshift = RST_TOTAL_SHIFT;
    cfg_lshift = RST_LIST_SHIFT; cfg_min = RST_MIN_INACTIVE;
  endfunction

  function automatic void unlink_page(int p, bit on_act);
    int nx, pv;
    nx = nxt[p]; pv = prv[p];
    if (pv < NIL) nxt[pv] = nx; else if (on_act) ahd = nx; else ihd = nx;
    if (nx < NIL) prv[nx] = pv; else if (on_act) atl = pv; else itl = pv;
    nxt[p] = NIL; prv[p] = NIL;
    if (on_act) begin
      if (alen > 0) alen--;
    end else begin
      if (ilen > 0) ilen--;
    end
  endfunction

  function automatic void push_front(int p, bit on_act);
    int h;
    h = on_act ? ahd : ihd;
    prv[p] = NIL; nxt[p] = h;
    if (h < NIL) prv[h] = p; else if (on_act) atl = p; else itl = p;
    if (on_act) begin
      ahd = p; alen++;
    end else begin
      ihd = p; ilen++;
    end
  endfunction

  function automatic void detach_page(int p);
    if (site[p] == SITE_INACTIVE) unlink_page(p, 0);
    else if (site[p] == SITE_ACTIVE) unlink_page(p, 1);
    site[p] = SITE_NONE;
  endfunction

  function automatic void move_to_head(int p, bit on_act);
    detach_page(p);
    push_front(p, on_act);
    site[p] = on_act ? SITE_ACTIVE : SITE_INACTIVE;
  endfunction

  // Touching a referenced, not yet active page marks it active, moving it when promote is set.
  function automatic void touch_page(int p, bit promote);
    if (!refm[p]) refm[p] = 1;
    else if (!actm[p]) begin
      if (promote) move_to_head(p, 1);
      refm[p] = 0; actm[p] = 1;
    end
  endfunction

  function automatic void demote_page(int p);
    detach_page(p);
    refm[p] = 0; actm[p] = 0;
    move_to_head(p, 0);
  endfunction

  function automatic lru_result_t predict_lru(lru_cmd_t op);
    lru_result_t r;
    int p, q, pv, cnt, guard;
    longint ina, actl;
    bit low;
    r = '0; p = op.page; cnt = 0; low = 0;
    case (op.cmd)
      CMD_ALLOC: if (itl < NIL) begin
        q = itl; detach_page(q); refm[q] = 0; actm[q] = 0;
        r.page_out = q[9:0]; r.found = 1'b1;
      end
      CMD_ADD: move_to_head(p, actm[p]);
      CMD_SETBACK: begin
        detach_page(p);
        nxt[p] = NIL; prv[p] = itl;
        if (itl < NIL) nxt[itl] = p; else ihd = p;
        itl = p; ilen++; site[p] = SITE_INACTIVE;
      end
      CMD_DELETE: if (site[p] == SITE_INACTIVE || site[p] == SITE_ACTIVE) detach_page(p);
      CMD_RD_MISS: begin
        move_to_head(p, 0); refm[p] = 1;
      end
      CMD_RD_HIT: if (op.wb) touch_page(p, !actm[p] && refm[p]);
                  else touch_page(p, site[p] == SITE_INACTIVE);
      CMD_WR_MISS: begin
        detach_page(p); refm[p] = 1; site[p] = SITE_RADIX;
      end
      CMD_WR_HIT: begin
        detach_page(p); touch_page(p, 0); site[p] = SITE_RADIX;
      end
      CMD_WB_RETURN: move_to_head(p, op.ta);
      CMD_REBALANCE: if (alen > 0) begin
        ina = ilen; actl = alen;
        if ((ina << cfg_tshift) > longint'(cfg_total)) low = 0;
        else if (ina < cfg_min) begin low = 1; cnt = alen; end
        else if ((actl << cfg_lshift) > ina) begin low = 1; cnt = alen >> 1; end
        if (low) begin
          if (cnt > alen) cnt = alen;
          for (int k = 0; k < cnt; k++) begin
            if (atl >= NIL) break;
            demote_page(atl); r.moved++;
          end
        end
      end
      CMD_SHRINK: begin
        for (int i = 0; i < NPG; i++) if (site[i] == SITE_INACTIVE) refm[i] = 0;
        q = atl; guard = 0;
        while (q < NIL && guard < NPG) begin
          pv = prv[q];
          if (refm[q]) refm[q] = 0;
          else begin demote_page(q); r.moved++; end
          q = pv; guard++;
        end
      end
      default: ;
    endcase
    r.inact = ilen[10:0];
    r.act = alen[10:0];
    return r;
  endfunction

  // Result side: check, draw a stall per result, watch for a hang.
  int stall_left = 0;
  int quiet = 0;
  always @(posedge clk) begin
    lru_result_t e;
    int draw;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (page_out !== e.page_out) begin
            $error("page_out exp %0d got %0d", e.page_out, page_out); errs++;
          end
          if (found !== e.found) begin
            $error("found exp %0d got %0d", e.found, found); errs++;
          end
          if (inactive_count !== e.inact) begin
            $error("inactive_count exp %0d got %0d", e.inact, inactive_count); errs++;
          end
          if (active_count !== e.act) begin
            $error("active_count exp %0d got %0d", e.act, active_count); errs++;
          end
          if (moved !== e.moved) begin
            $error("moved exp %0d got %0d", e.moved, moved); errs++;
          end
        end
        draw = no_idle ? 0 : $urandom_range(0, 15);
        stall_left <= draw;
        out_stall <= (draw != 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end
      // Count cycles with no transaction on either channel.
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Hold the transaction until taken, then queue its prediction or the typed result.
  task automatic send_cmd(lru_cmd_t op, bit typed, lru_result_t typed_res);
    int gap;
    lru_result_t r;
    in_valid <= 1'b1;
    cmd <= op.cmd; page <= op.page; in_writeback <= op.wb; to_active <= op.ta;
    do @(posedge clk); while (in_stall);
    r = predict_lru(op);
    expected_results.push_back(typed ? typed_res : r);
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain, let the block settle, then write all four registers.
  task automatic set_config(int tp, int ts, int ls, int mi);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[1:0];
      case (i[1:0])
        REG_TOTAL_PAGES: cfg_data <= tp[10:0];
        REG_TOTAL_SHIFT: cfg_data <= ts[10:0];
        REG_LIST_SHIFT:  cfg_data <= ls[10:0];
        default:         cfg_data <= mi[10:0];
      endcase
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cfg_total = tp; cfg_tshift = ts; cfg_lshift = ls; cfg_min = mi;
  endtask

  function automatic lru_cmd_t random_cmd();
    lru_cmd_t op;
    int w;
    w = $urandom_range(0, 99);
    if (w < 12) op.cmd = CMD_ALLOC;
    else if (w < 22) op.cmd = CMD_ADD;
    else if (w < 28) op.cmd = CMD_SETBACK;
    else if (w < 35) op.cmd = CMD_DELETE;
    else if (w < 50) op.cmd = CMD_RD_MISS;
    else if (w < 68) op.cmd = CMD_RD_HIT;
    else if (w < 73) op.cmd = CMD_WR_MISS;
    else if (w < 79) op.cmd = CMD_WR_HIT;
    else if (w < 88) op.cmd = CMD_WB_RETURN;
    else if (w < 95) op.cmd = CMD_REBALANCE;
    else if (w < 98) op.cmd = CMD_SHRINK;
    else op.cmd = 4'($urandom_range(11, 15));
    // Keep most traffic on a small page set so the lists grow and churn.
    op.page = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, 47));
    op.wb = $urandom_range(0, 1);
    op.ta = $urandom_range(0, 1);
    return op;
  endfunction

  table_row_t rows[$];

  function automatic table_row_t row(logic [3:0] c, int p, bit wb, bit ta,
                                     bit typed, int ic, int ac);
    table_row_t t;
    t.op.cmd = c; t.op.page = p[9:0]; t.op.wb = wb; t.op.ta = ta;
    t.typed = typed;
    t.res = '0; t.res.inact = ic[10:0]; t.res.act = ac[10:0];
    return t;
  endfunction

  initial begin
    lists_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty lists first, then the extreme pages and every command.
    rows.push_back(row(CMD_ALLOC, 0, 0, 0, 1, 0, 0));
    rows.push_back(row(CMD_SHRINK, 0, 0, 0, 1, 0, 0));
    rows.push_back(row(CMD_REBALANCE, 0, 0, 0, 1, 0, 0));
    rows.push_back(row(CMD_RD_MISS, 1023, 0, 0, 1, 1, 0));
    rows.push_back(row(CMD_RD_MISS, 0, 0, 0, 1, 2, 0));
    rows.push_back(row(CMD_RD_HIT, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_RD_HIT, 1023, 1, 0, 0, 0, 0));
    rows.push_back(row(CMD_RD_HIT, 1023, 1, 0, 0, 0, 0));
    rows.push_back(row(CMD_ADD, 5, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_SETBACK, 6, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_WB_RETURN, 7, 0, 1, 0, 0, 0));
    rows.push_back(row(CMD_WB_RETURN, 8, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_WR_MISS, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_WR_HIT, 9, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_WR_HIT, 9, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_ADD, 9, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_DELETE, 7, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_DELETE, 7, 0, 0, 0, 0, 0));
    rows.push_back(row(4'd15, 682, 1, 1, 0, 0, 0));
    rows.push_back(row(CMD_REBALANCE, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_SHRINK, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_ALLOC, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_SETBACK, 682, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_RD_MISS, 341, 0, 0, 0, 0, 0));

    @(posedge clk);
    set_config(RST_TOTAL_PAGES, RST_TOTAL_SHIFT, RST_LIST_SHIFT, RST_MIN_INACTIVE);
    foreach (rows[i]) send_cmd(rows[i].op, rows[i].typed, rows[i].res);

    // Random phases, mostly at the register extremes; each run of 70 commands goes
    // without idling on either side with a chance of one in three.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(1024, 1, 1, 32);
        1: set_config(0, 0, 0, 0);
        2: set_config(1024, 10, 10, 1024);
        default: set_config(64, 2, 3, 8);
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 70 == 0) no_idle = ($urandom_range(0, 2) == 0);
        send_cmd(random_cmd(), 0, '0);
      end
      no_idle = 0;
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
